@@ hdl/rational_arithmetic_unit_assert.svh @@
// Assertion macros for the rational arithmetic unit.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational arithmetic unit: assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational arithmetic unit: assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, operation codes and word types.
// Used by rau_reduce, rational_arithmetic_unit and its testbench; depends on nothing.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int NUM_WIDTH     = 33;
  localparam int DEN_WIDTH     = 32;
  localparam int FUNC_WIDTH    = 4;

  // Operation codes.
  localparam logic [FUNC_WIDTH-1:0] F_ADD    = 4'd0;
  localparam logic [FUNC_WIDTH-1:0] F_SUB    = 4'd1;
  localparam logic [FUNC_WIDTH-1:0] F_MUL    = 4'd2;
  localparam logic [FUNC_WIDTH-1:0] F_DIV    = 4'd3;
  localparam logic [FUNC_WIDTH-1:0] F_GT     = 4'd4;
  localparam logic [FUNC_WIDTH-1:0] F_LT     = 4'd5;
  localparam logic [FUNC_WIDTH-1:0] F_EQ     = 4'd6;
  localparam logic [FUNC_WIDTH-1:0] F_GE     = 4'd7;
  localparam logic [FUNC_WIDTH-1:0] F_LE     = 4'd8;
  localparam logic [FUNC_WIDTH-1:0] F_REDUCE = 4'd9;

  // Input word: operation code and two fractions.
  typedef struct packed {
    logic [FUNC_WIDTH-1:0]           func;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] res_num;
    logic signed [DEN_WIDTH-1:0] res_den;
    logic                        cmp_true;
    logic                        bad_den;
  } out_word_t;

endpackage

@@ hdl/rau_reduce.sv @@
// Fraction reduction for the rational arithmetic unit: binary gcd, then two
// restoring divisions, all on one shared subtractor. Depends on rau_pkg.
`include "rational_arithmetic_unit_assert.svh"

module rau_reduce (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0]  num,
  input  logic [rau_pkg::OPERAND_WIDTH-1:0]  den,
  output logic                               done,
  output logic [rau_pkg::OPERAND_WIDTH-1:0]  q_num,
  output logic [rau_pkg::OPERAND_WIDTH-1:0]  q_den
);

  localparam int W  = rau_pkg::OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  localparam logic [2:0] R_IDLE  = 3'd0;
  localparam logic [2:0] R_GCD   = 3'd1;
  localparam logic [2:0] R_SHIFT = 3'd2;
  localparam logic [2:0] R_DIVN  = 3'd3;
  localparam logic [2:0] R_DIVD  = 3'd4;

  logic [2:0]    state;
  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [CW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;

  logic [W:0]    t;
  logic [W:0]    sub_a;
  logic [W:0]    sub_b;
  logic [W:0]    sub_d;
  logic [W:0]    mag;
  logic          neg;
  logic [W-1:0]  half;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  quo_next;
  logic          last;
  logic          gcd_end;

  // Shared subtractor: x - y during the gcd, partial remainder - g while dividing.
  always_comb begin
    t     = {rem, quo[W-1]};
    sub_a = (state == R_GCD) ? {1'b0, x} : t;
    sub_b = (state == R_GCD) ? {1'b0, y} : {1'b0, g};
    sub_d = sub_a - sub_b;
    neg   = sub_d[W];
    mag   = neg ? ((W+1)'(0) - sub_d) : sub_d;
    half  = mag[W:1];
  end

  // One restoring division step and the loop end tests.
  always_comb begin
    rem_next = neg ? t[W-1:0] : sub_d[W-1:0];
    quo_next = {quo[W-2:0], ~neg};
    last     = (cnt == CW'(W - 1));
    gcd_end  = (x == '0) || (y == '0);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (go) state <= R_GCD;
        end
        R_GCD: begin
          if (gcd_end) state <= R_SHIFT;
        end
        R_SHIFT: begin
          state <= R_DIVN;
        end
        R_DIVN: begin
          if (last) state <= R_DIVD;
        end
        R_DIVD: begin
          if (last) begin
            state <= R_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  // Datapath. The operands stay stable at the ports for the whole run.
  always_ff @(posedge clk) begin
    case (state)
      R_IDLE: begin
        if (go) begin
          x <= num;
          y <= den;
          k <= '0;
        end
      end
      R_GCD: begin
        // Stein's steps: strip common twos, strip lone twos, halve the odd difference.
        if (!gcd_end) begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + CW'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (neg) begin
            y <= half;
          end else begin
            x <= half;
          end
        end
      end
      R_SHIFT: begin
        g   <= (x | y) << k;
        rem <= '0;
        quo <= num;
        cnt <= '0;
      end
      R_DIVN: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + CW'(1);
        if (last) begin
          q_num <= quo_next;
          rem   <= '0;
          quo   <= den;
          cnt   <= '0;
        end
      end
      R_DIVD: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + CW'(1);
        if (last) q_den <= quo_next;
      end
      default: begin
      end
    endcase
  end

  // The gcd ends with exactly one part at zero, since both inputs are positive.
  `ASSERT_IMPL(a_gcd_one_zero, clk, rst, state == R_SHIFT, (x == '0) != (y == '0))
  // A new run is started only while the unit is idle.
  `ASSERT_IMPL(a_go_when_idle, clk, rst, go, state == R_IDLE)
  // Completion follows the last step of the second division.
  `ASSERT_IMPL(a_done_after_div, clk, rst, done, $past(state) == R_DIVD)

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: operation sequencer and shared multiplier.
// Depends on rau_pkg and rau_reduce.
`include "rational_arithmetic_unit_assert.svh"

// Arithmetic and exact compares on two 16-bit fractions, one word at a time.
// A word is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and must be taken then.
// Add, subtract, multiply, divide and the five compares run three products
// through one 16x16 multiplier in S_MUL0, S_MUL1 and S_MUL2, then done is
// registered from S_FIN; a new word can be taken at the edge that ends the done cycle.
// Unused codes and a reduce whose numerator or denominator is not positive go
// straight to S_FIN. A reduce with positive parts runs, in S_RED, a binary gcd
// and two 16-step restoring divisions on one shared subtractor, and done
// follows the end of the second division.
module rational_arithmetic_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rau_pkg::in_word_t   operands,
  output logic                busy,
  output logic                done,
  output rau_pkg::out_word_t  result
);

  localparam int W  = rau_pkg::OPERAND_WIDTH;
  localparam int PW = rau_pkg::PROD_WIDTH;
  localparam int NW = rau_pkg::NUM_WIDTH;
  localparam int DW = rau_pkg::DEN_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_RED  = 3'd5;

  logic [2:0]          state;
  rau_pkg::in_word_t   opr;
  logic signed [PW-1:0] x_prod;
  logic signed [PW-1:0] y_prod;
  logic signed [PW-1:0] z_prod;
  logic                red_go;

  logic                accept;
  logic                fin;
  logic                a_pos;
  logic signed [W-1:0] ma;
  logic signed [W-1:0] mb;
  logic signed [PW-1:0] prod;
  logic                red_done;
  logic [W-1:0]        q_num;
  logic [W-1:0]        q_den;
  rau_pkg::out_word_t  res_next;

  logic [NW-1:0]       x_ext;
  logic [NW-1:0]       y_ext;
  logic [NW-1:0]       sum;
  logic                do_sub;
  logic                adz;
  logic                bdz;
  logic                bnz;
  logic                flip;
  logic                gt_raw;
  logic                lt_raw;
  logic                eq;
  logic                gt;
  logic                lt;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign a_pos  = !operands.a_num[W-1] && (operands.a_num != '0) &&
                  !operands.a_den[W-1] && (operands.a_den != '0);
  assign fin    = (state == S_FIN) || ((state == S_RED) && red_done);

  // Shared multiplier operand select: X in MUL0, Y in MUL1, Z (denominator) in MUL2.
  always_comb begin
    ma = opr.a_num;
    mb = opr.b_den;
    case (state)
      S_MUL0: begin
        ma = opr.a_num;
        mb = (opr.func == rau_pkg::F_MUL) ? opr.b_num : opr.b_den;
      end
      S_MUL1: begin
        ma = opr.b_num;
        mb = opr.a_den;
      end
      S_MUL2: begin
        ma = opr.a_den;
        mb = (opr.func == rau_pkg::F_DIV) ? opr.b_num : opr.b_den;
      end
      default: begin
      end
    endcase
    prod = ma * mb;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      red_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      red_go <= 1'b0;
      done   <= fin;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operands.func <= rau_pkg::F_LE) begin
              state <= S_MUL0;
            end else if ((operands.func == rau_pkg::F_REDUCE) && a_pos) begin
              state  <= S_RED;
              red_go <= 1'b1;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_FIN;
        S_FIN:  state <= S_IDLE;
        S_RED: begin
          if (red_done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operand, product and result registers.
  always_ff @(posedge clk) begin
    if (accept) opr <= operands;
    if (state == S_MUL0) x_prod <= prod;
    if (state == S_MUL1) y_prod <= prod;
    if (state == S_MUL2) z_prod <= prod;
    if (fin) result <= res_next;
  end

  // Cross-product sum or difference; compares look at the sign and zero test of X - Y.
  always_comb begin
    x_ext  = {{(NW-PW){x_prod[PW-1]}}, x_prod};
    y_ext  = {{(NW-PW){y_prod[PW-1]}}, y_prod};
    do_sub = (opr.func != rau_pkg::F_ADD);
    sum    = x_ext + (y_ext ^ {NW{do_sub}}) + NW'(do_sub);
    adz    = (opr.a_den == '0);
    bdz    = (opr.b_den == '0);
    bnz    = (opr.b_num == '0);
    // Opposite denominator signs reverse the order of the cross products.
    flip   = opr.a_den[W-1] ^ opr.b_den[W-1];
    lt_raw = sum[NW-1];
    eq     = (sum == '0);
    gt_raw = !lt_raw && !eq;
    gt     = flip ? lt_raw : gt_raw;
    lt     = flip ? gt_raw : lt_raw;
  end

  // Result word for the finishing cycle.
  always_comb begin
    res_next = '0;
    case (opr.func)
      rau_pkg::F_ADD, rau_pkg::F_SUB: begin
        res_next.res_num = sum;
        res_next.res_den = DW'(z_prod);
        res_next.bad_den = adz || bdz;
      end
      rau_pkg::F_MUL: begin
        res_next.res_num = x_ext;
        res_next.res_den = DW'(z_prod);
        res_next.bad_den = adz || bdz;
      end
      rau_pkg::F_DIV: begin
        res_next.res_num = x_ext;
        res_next.res_den = DW'(z_prod);
        res_next.bad_den = adz || bdz || bnz;
      end
      rau_pkg::F_GT: begin
        res_next.bad_den  = adz || bdz;
        res_next.cmp_true = !(adz || bdz) && gt;
      end
      rau_pkg::F_LT: begin
        res_next.bad_den  = adz || bdz;
        res_next.cmp_true = !(adz || bdz) && lt;
      end
      rau_pkg::F_EQ: begin
        res_next.bad_den  = adz || bdz;
        res_next.cmp_true = !(adz || bdz) && eq;
      end
      rau_pkg::F_GE: begin
        res_next.bad_den  = adz || bdz;
        res_next.cmp_true = !(adz || bdz) && (gt || eq);
      end
      rau_pkg::F_LE: begin
        res_next.bad_den  = adz || bdz;
        res_next.cmp_true = !(adz || bdz) && (lt || eq);
      end
      rau_pkg::F_REDUCE: begin
        if (state == S_RED) begin
          res_next.res_num = NW'(q_num);
          res_next.res_den = DW'(q_den);
        end else begin
          // A part that is not positive: the fraction passes unchanged.
          res_next.res_num = {{(NW-W){opr.a_num[W-1]}}, opr.a_num};
          res_next.res_den = {{(DW-W){opr.a_den[W-1]}}, opr.a_den};
          res_next.bad_den = adz;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Reduction unit; opr holds its operands steady while it runs.
  rau_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .go    (red_go),
    .num   (opr.a_num),
    .den   (opr.a_den),
    .done  (red_done),
    .q_num (q_num),
    .q_den (q_den)
  );

  // The strobe comes with the block already free for the next word.
  `ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  // An accepted word always makes the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // The reduction unit finishes only while the sequencer waits for it.
  `ASSERT_IMPL(a_red_done_state, clk, rst, red_done, state == S_RED)

endmodule

@@ test/rational_arithmetic_unit_tb.sv @@
// Self-checking testbench for rational_arithmetic_unit: directed fraction words, then random ones.
// Depends on rau_pkg and the rational_arithmetic_unit RTL only.
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_WORDS = 1250;
  localparam int BURST_LEN    = 50;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 1_000_000;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  rau_pkg::in_word_t  operands;
  logic               busy;
  logic               done;
  rau_pkg::out_word_t result;

  rational_arithmetic_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Holds the expected result of every accepted word, oldest first.
  class fraction_ledger;
    rau_pkg::out_word_t pending_results[$];
    int errors = 0;
    int words = 0;
    int results = 0;
    int gcd_reductions = 0;
    int flagged = 0;
    int compares_true = 0;

    // Computes the result word that a fraction word must produce.
    function rau_pkg::out_word_t fraction_result(rau_pkg::in_word_t w);
      rau_pkg::out_word_t r;
      longint an, ad, bn, bd, lhs, rhs, x, y, t;
      bit holds;
      r = '0;
      holds = 1'b0;
      an = $signed(w.a_num);
      ad = $signed(w.a_den);
      bn = $signed(w.b_num);
      bd = $signed(w.b_den);
      case (w.func)
        rau_pkg::F_ADD, rau_pkg::F_SUB, rau_pkg::F_MUL, rau_pkg::F_DIV: begin
          r.bad_den = (ad == 0 || bd == 0);
          if (w.func == rau_pkg::F_ADD) lhs = an * bd + bn * ad;
          else if (w.func == rau_pkg::F_SUB) lhs = an * bd - bn * ad;
          else if (w.func == rau_pkg::F_MUL) lhs = an * bn;
          else lhs = an * bd;
          rhs = (w.func == rau_pkg::F_DIV) ? ad * bn : ad * bd;
          if (w.func == rau_pkg::F_DIV && bn == 0) r.bad_den = 1'b1;
          // Products wrap to the result widths.
          r.res_num = lhs[rau_pkg::NUM_WIDTH-1:0];
          r.res_den = rhs[rau_pkg::DEN_WIDTH-1:0];
        end
        rau_pkg::F_GT, rau_pkg::F_LT, rau_pkg::F_EQ, rau_pkg::F_GE, rau_pkg::F_LE: begin
          if (ad == 0 || bd == 0) begin
            r.bad_den = 1'b1;
          end else begin
            // Cross multiply; flip both sides when the denominators differ in sign.
            lhs = an * bd;
            rhs = bn * ad;
            if ((ad < 0) != (bd < 0)) begin
              lhs = -lhs;
              rhs = -rhs;
            end
            case (w.func)
              rau_pkg::F_GT: holds = lhs > rhs;
              rau_pkg::F_LT: holds = lhs < rhs;
              rau_pkg::F_EQ: holds = lhs == rhs;
              rau_pkg::F_GE: holds = lhs >= rhs;
              default: holds = lhs <= rhs;
            endcase
            r.cmp_true = holds;
          end
        end
        rau_pkg::F_REDUCE: begin
          r.bad_den = (ad == 0);
          if (an > 0 && ad > 0) begin
            x = an;
            y = ad;
            while (y != 0) begin
              t = x % y;
              x = y;
              y = t;
            end
            an = an / x;
            ad = ad / x;
          end
          r.res_num = an[rau_pkg::NUM_WIDTH-1:0];
          r.res_den = ad[rau_pkg::DEN_WIDTH-1:0];
        end
        default: ;
      endcase
      return r;
    endfunction

    // Records an accepted word and queues what it must produce.
    function void note_word(rau_pkg::in_word_t w);
      rau_pkg::out_word_t exp;
      exp = fraction_result(w);
      words++;
      if (exp.bad_den) flagged++;
      if (exp.cmp_true) compares_true++;
      if (w.func == rau_pkg::F_REDUCE && $signed(w.a_num) > 0 && $signed(w.a_den) > 0)
        gcd_reductions++;
      pending_results.push_back(exp);
    endfunction

    // Compares a result word with the oldest expectation.
    function void check_result(rau_pkg::out_word_t got);
      rau_pkg::out_word_t exp;
      if (pending_results.size() == 0) begin
        $error("result word with no word pending: res_num %0d res_den %0d",
               $signed(got.res_num), $signed(got.res_den));
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      results++;
      if (got.res_num !== exp.res_num) begin
        $error("res_num: expected %0d, got %0d", $signed(exp.res_num), $signed(got.res_num));
        errors++;
      end
      if (got.res_den !== exp.res_den) begin
        $error("res_den: expected %0d, got %0d", $signed(exp.res_den), $signed(got.res_den));
        errors++;
      end
      if (got.cmp_true !== exp.cmp_true) begin
        $error("cmp_true: expected %0b, got %0b", exp.cmp_true, got.cmp_true);
        errors++;
      end
      if (got.bad_den !== exp.bad_den) begin
        $error("bad_den: expected %0b, got %0b", exp.bad_den, got.bad_den);
        errors++;
      end
    endfunction
  endclass

  fraction_ledger ledger = new();

  // Result words are valid for exactly one cycle.
  always @(posedge clk) begin
    if (!rst && done) ledger.check_result(result);
  end

  function automatic rau_pkg::in_word_t fraction_word(logic [rau_pkg::FUNC_WIDTH-1:0] f,
                                                      int an, int ad, int bn, int bd);
    rau_pkg::in_word_t w;
    w.func  = f;
    w.a_num = an[rau_pkg::OPERAND_WIDTH-1:0];
    w.a_den = ad[rau_pkg::OPERAND_WIDTH-1:0];
    w.b_num = bn[rau_pkg::OPERAND_WIDTH-1:0];
    w.b_den = bd[rau_pkg::OPERAND_WIDTH-1:0];
    return w;
  endfunction

  // Mostly full-range values, with extremes, zero and small values mixed in.
  function automatic int pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return -32768;
        1: return 32767;
        2: return 0;
        3: return 1;
        default: return -1;
      endcase
    end else if (sel <= 3) begin
      return $signed($urandom_range(0, 40)) - 20;
    end
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic rau_pkg::in_word_t random_fraction_word();
    rau_pkg::in_word_t w;
    logic [rau_pkg::FUNC_WIDTH-1:0] f;
    int g;
    if ($urandom_range(0, 99) < 8) f = rau_pkg::FUNC_WIDTH'($urandom_range(10, 15));
    else f = rau_pkg::FUNC_WIDTH'($urandom_range(rau_pkg::F_ADD, rau_pkg::F_REDUCE));
    w = fraction_word(f, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    // Reduce mostly gets positive parts that share a factor.
    if (f == rau_pkg::F_REDUCE && $urandom_range(0, 3) != 0) begin
      g = $urandom_range(1, 181);
      w.a_num = rau_pkg::OPERAND_WIDTH'(g * $urandom_range(1, 181));
      w.a_den = rau_pkg::OPERAND_WIDTH'(g * $urandom_range(1, 181));
    end
    // Compares often see the same value, written two ways.
    if (f >= rau_pkg::F_GT && f <= rau_pkg::F_LE && $urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        w.b_num = w.a_num;
        w.b_den = w.a_den;
      end else begin
        w.b_num = -w.a_num;
        w.b_den = -w.a_den;
      end
    end
    return w;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Idles for the given gap, then holds the word until the block takes it.
  task automatic send_word(rau_pkg::in_word_t w, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      operands <= rau_pkg::in_word_t'({$urandom, $urandom, $urandom});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    operands <= w;
    do @(posedge clk); while (busy);
    ledger.note_word(w);
  endtask

  initial begin
    rau_pkg::in_word_t directed[$];
    bit quiet;
    rst = 1'b1;
    start = 1'b0;
    operands = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Extremes, each operation, zero denominators, the reduce corner cases and two unused codes.
    directed.push_back(fraction_word(rau_pkg::F_ADD, -32768, -32768, -32768, -32768));
    directed.push_back(fraction_word(rau_pkg::F_ADD, 32767, 32767, 32767, 1));
    directed.push_back(fraction_word(rau_pkg::F_SUB, 32767, -32768, -32768, 32767));
    directed.push_back(fraction_word(rau_pkg::F_MUL, -32768, 32767, -32768, -32768));
    directed.push_back(fraction_word(rau_pkg::F_DIV, 7, 3, 0, 5));
    directed.push_back(fraction_word(rau_pkg::F_DIV, -32768, -1, 32767, -32768));
    directed.push_back(fraction_word(rau_pkg::F_ADD, 1, 0, 1, 2));
    directed.push_back(fraction_word(rau_pkg::F_SUB, 0, 0, 0, 0));
    directed.push_back(fraction_word(rau_pkg::F_GT, 1, -2, -1, 3));
    directed.push_back(fraction_word(rau_pkg::F_LT, 1, 2, 2, 3));
    directed.push_back(fraction_word(rau_pkg::F_EQ, 2, 4, -1, -2));
    directed.push_back(fraction_word(rau_pkg::F_GE, 3, 6, 1, 2));
    directed.push_back(fraction_word(rau_pkg::F_LE, -32768, 1, 32767, -1));
    directed.push_back(fraction_word(rau_pkg::F_GT, 1, 0, 1, 1));
    directed.push_back(fraction_word(rau_pkg::F_EQ, 0, 5, 0, -7));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 12, 18, 0, 0));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 32767, 32767, 5, 0));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, -12, 18, 1, 1));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 5, 0, 1, 1));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 0, 7, 1, 1));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 32767, -32768, 1, 1));
    directed.push_back(fraction_word(rau_pkg::F_REDUCE, 1, 1, 0, 0));
    directed.push_back(fraction_word(4'd10, 3, 4, 5, 6));
    directed.push_back(fraction_word(4'd15, -1, -1, -1, -1));
    foreach (directed[i]) send_word(directed[i], $urandom_range(0, 3));

    // Random words in bursts, some back to back and some with gaps.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % BURST_LEN == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(random_fraction_word(), quiet ? 0 : pick_gap());
    end
    @(negedge clk);
    start <= 1'b0;

    // Let every outstanding result arrive, then watch for strays.
    while (ledger.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.pending_results.size() != 0)
      $error("%0d expected results never arrived", ledger.pending_results.size());
    $display("Sent %0d words and checked %0d results, including %0d gcd reductions,",
             ledger.words, ledger.results, ledger.gcd_reductions);
    $display("%0d flagged denominators and %0d compares that held.",
             ledger.flagged, ledger.compares_true);
    if (ledger.errors == 0 && ledger.pending_results.size() == 0)
      $display("rational_arithmetic_unit verification clean");
    else
      $display("rational_arithmetic_unit verification failed");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $error("timeout after %0d cycles", LIMIT_CYCLES);
    $display("rational_arithmetic_unit verification failed");
    $finish;
  end

endmodule
